[hdl/ksr_pkg.sv]
// Shared types, constants and helper functions of the Kaczmarz signal restorer.
// Used by ksr_div, ksr_core and kaczmarz_signal_restorer; depends on nothing.
package ksr_pkg;

	localparam int QUOT_W = 32;
	localparam int DIVN_W = 74;
	localparam int NORM_SHIFT = 20;
	localparam int PROD_SHIFT = 30;
	localparam int EST_FRAC = 14;
	localparam int STEP_SHIFT = 26;

	localparam logic [6:0] SIGNAL_LENGTH_RST = 7'd64;
	localparam logic [5:0] PATTERN_LENGTH_RST = 6'd32;
	localparam logic [15:0] RELAX_GAIN_RST = 16'd16384;
	localparam logic [9:0] SWEEP_COUNT_RST = 10'd10;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [6:0]  signal_length;
		logic [5:0]  pattern_length;
		logic [15:0] relax_gain;
		logic [9:0]  sweep_count;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[hdl/ksr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ksr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/ksr_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, with overflow detect.
// Depends on ksr_pkg for the quotient width and the response struct.
module ksr_div import ksr_pkg::*; #(
	parameter int NUM_W = 74,
	parameter int DEN_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output div_rsp_t         rsp
);

	localparam int HI_W = NUM_W - QUOT_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUOT_W-1:0] low_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic              ovf_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			low_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q <= divisor;
				low_q <= dividend[QUOT_W-1:0];
				rem_q <= DEN_W'(dividend[NUM_W-1:QUOT_W]);
				if (CMP_W'(dividend[NUM_W-1:QUOT_W]) >= CMP_W'(divisor)) begin
					ovf_q <= 1'b1;
					done_q <= 1'b1;
					run_q <= 1'b0;
				end else begin
					ovf_q <= 1'b0;
					run_q <= 1'b1;
					cnt_q <= CNT_W'(QUOT_W);
				end
			end else if (run_q) begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				low_q <= {low_q[QUOT_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, ovf: ovf_q, quot: low_q};

endmodule

[hdl/ksr_core.sv]
// Sequencer of the restorer: pattern build, row norms, Kaczmarz sweeps, readout.
// Depends on ksr_pkg, ksr_ram for all stores and ksr_div for the divisions.
module ksr_core import ksr_pkg::*; #(
	parameter int MAX_SIGNAL = 64,
	parameter int MAX_TAPS = 32,
	parameter int PAD_MULTIPLE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               start,
	input  logic               action,
	input  logic signed [15:0] value,
	input  logic signed [15:0] position,
	output logic               busy,
	output logic               strobe,
	output logic signed [15:0] restored_sample,
	output logic [5:0]         sample_index,
	output logic               last
);

	localparam int SIG_CAP = MAX_SIGNAL + PAD_MULTIPLE;
	localparam int SAW = $clog2(SIG_CAP);
	localparam int SKW = $clog2(SIG_CAP + 1);
	localparam int TAW = $clog2(MAX_TAPS);
	localparam int TKW = $clog2(MAX_TAPS + 1);
	localparam int LW = $clog2(MAX_SIGNAL + 1);
	localparam int MW = (PAD_MULTIPLE > 1) ? $clog2(PAD_MULTIPLE) : 1;
	localparam int NORM_W = 43 + $clog2(MAX_TAPS);
	localparam int S2_W = 34 + $clog2(MAX_TAPS);
	localparam int DOT_W = 35 + $clog2(MAX_TAPS);
	localparam int CW = $clog2(SIG_CAP + MAX_TAPS) + 2;

	typedef enum logic [23:0] {
		S_IDLE   = 24'h000001,
		S_PACC   = 24'h000002,
		S_BRD    = 24'h000004,
		S_BSTART = 24'h000008,
		S_BWAIT  = 24'h000010,
		S_INIT   = 24'h000020,
		S_NK     = 24'h000040,
		S_NMUL   = 24'h000080,
		S_NACC   = 24'h000100,
		S_RROW   = 24'h000200,
		S_RNORM  = 24'h000400,
		S_DK     = 24'h000800,
		S_DMUL   = 24'h001000,
		S_DACC   = 24'h002000,
		S_RES    = 24'h004000,
		S_MAG    = 24'h008000,
		S_DWAIT  = 24'h010000,
		S_UK     = 24'h020000,
		S_UMUL   = 24'h040000,
		S_UWR    = 24'h080000,
		S_CRD    = 24'h100000,
		S_CWR    = 24'h200000,
		S_ORD    = 24'h400000,
		S_OUT    = 24'h800000
	} state_t;

	state_t                    state_q;
	logic [TKW-1:0]            pat_cnt_q;
	logic [LW-1:0]             smp_cnt_q;
	logic signed [15:0]        prev_val_q;
	logic signed [15:0]        prev_pos_q;
	logic signed [33:0]        term_q;
	logic                      term_en_q;
	logic signed [S2_W-1:0]    s2_q;
	logic                      zero_seen_q;
	logic [TAW-1:0]            zero_idx_q;
	logic [TAW-1:0]            centre_q;
	logic [TKW-1:0]            tap_cnt_q;
	logic [TKW-1:0]            bp_q;
	logic [TKW-1:0]            j_q;
	logic                      neg_q;
	logic [SKW-1:0]            i_q;
	logic [MW-1:0]             m_q;
	logic [SKW-1:0]            n_q;
	logic [LW-1:0]             len_q;
	logic [TKW-1:0]            k_q;
	logic [NORM_W-1:0]         acc_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic [NORM_W-1:0]         norm_q;
	logic signed [15:0]        meas_q;
	logic signed [31:0]        r_q;
	logic signed [31:0]        step_q;
	logic [9:0]                sw_q;
	logic signed [63:0]        prod_s1;
	logic signed [31:0]        est_s1;
	logic                      tnz_s1;
	logic                      strobe_q;
	logic signed [15:0]        sample_q;
	logic [5:0]                index_q;
	logic                      last_q;

	logic                      acc_in;
	logic                      acc_pat;
	logic                      acc_sig;
	logic [TKW-1:0]            p_used;
	logic [LW-1:0]             len_used;
	logic [TKW-1:0]            pat_idx;
	logic [LW:0]               smp_next;
	logic signed [16:0]        sum_v;
	logic signed [16:0]        dif_p;
	logic signed [33:0]        term_p;
	logic [S2_W-1:0]           abs_s2;
	logic [16:0]               abs_v;
	logic signed [CW-1:0]      c_s;
	logic                      c_ok;
	logic [SAW-1:0]            c_addr;
	logic [31:0]               abs_r;
	logic [47:0]               mag;
	logic signed [31:0]        mul_a;
	logic signed [31:0]        mul_b;
	logic signed [63:0]        mul_p;
	logic signed [31:0]        div_tap;
	logic signed [31:0]        zero_tap;
	logic [31:0]               q_sat;
	logic signed [31:0]        est_upd;
	logic signed [18:0]        y_full;
	logic signed [15:0]        y_sat;
	logic                      row_last;
	logic                      div_start;
	logic [DIVN_W-1:0]         div_num;
	logic [NORM_W-1:0]         div_den;
	div_rsp_t                  div_rsp;

	logic                      raw_we;
	logic [TAW-1:0]            raw_raddr;
	logic signed [15:0]        raw_rd;
	logic                      tap_we;
	logic signed [31:0]        tap_wd;
	logic signed [31:0]        tap_rd;
	logic                      norm_we;
	logic [NORM_W-1:0]         norm_rd;
	logic                      meas_we;
	logic [SAW-1:0]            meas_waddr;
	logic signed [15:0]        meas_wd;
	logic signed [15:0]        meas_rd;
	logic                      est_we;
	logic [SAW-1:0]            est_waddr;
	logic [SAW-1:0]            est_raddr;
	logic signed [31:0]        est_wd;
	logic signed [31:0]        est_rd;

	assign busy = (state_q != S_IDLE);
	assign acc_in = start && !busy;
	assign acc_pat = acc_in && !action;
	assign acc_sig = acc_in && action;

	always_comb begin
		if (cfg.pattern_length < 6'd2) begin
			p_used = TKW'(2);
		end else if (int'(cfg.pattern_length) > MAX_TAPS) begin
			p_used = TKW'(MAX_TAPS);
		end else begin
			p_used = TKW'(cfg.pattern_length);
		end
		if (cfg.signal_length == 7'd0) begin
			len_used = LW'(1);
		end else if (int'(cfg.signal_length) > MAX_SIGNAL) begin
			len_used = LW'(MAX_SIGNAL);
		end else begin
			len_used = LW'(cfg.signal_length);
		end
	end

	assign pat_idx = (pat_cnt_q >= p_used) ? '0 : pat_cnt_q;
	assign smp_next = (LW + 1)'(smp_cnt_q) + 1'b1;
	assign sum_v = 17'(value) + 17'(prev_val_q);
	assign dif_p = 17'(position) - 17'(prev_pos_q);
	assign term_p = sum_v * dif_p;

	assign abs_s2 = s2_q[S2_W-1] ? S2_W'(-s2_q) : S2_W'(s2_q);
	assign abs_v = raw_rd[15] ? 17'(-17'(raw_rd)) : 17'(raw_rd);
	assign zero_tap = sat32(64'(raw_rd) <<< PROD_SHIFT);

	assign c_s = $signed(CW'(i_q)) + $signed(CW'(k_q)) - $signed(CW'(centre_q));
	assign c_ok = !c_s[CW-1] && (c_s < $signed(CW'(n_q)));
	assign c_addr = c_s[SAW-1:0];
	assign row_last = ((i_q + 1'b1) == n_q);

	assign abs_r = r_q[31] ? 32'(-r_q) : 32'(r_q);
	assign mag = 48'(cfg.relax_gain) * 48'(abs_r);

	always_comb begin
		mul_a = tap_rd;
		mul_b = tap_rd;
		case (state_q)
			S_DMUL: begin
				mul_b = est_rd;
			end
			S_UMUL: begin
				mul_a = step_q;
			end
			default: begin
				mul_a = tap_rd;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		if (neg_q) begin
			if (div_rsp.ovf || (div_rsp.quot > 32'h80000000)) begin
				div_tap = 32'sh80000000;
			end else begin
				div_tap = -$signed(div_rsp.quot);
			end
		end else begin
			if (div_rsp.ovf || div_rsp.quot[31]) begin
				div_tap = 32'sh7fffffff;
			end else begin
				div_tap = $signed(div_rsp.quot);
			end
		end
		q_sat = (div_rsp.ovf || div_rsp.quot[31]) ? 32'h7fffffff : div_rsp.quot;
	end

	assign est_upd = sat32(64'(est_s1) + (prod_s1 >>> PROD_SHIFT));
	assign y_full = 19'((33'(est_rd) + 33'sd8192) >>> EST_FRAC);
	assign y_sat = (y_full > 19'sd32767) ? 16'sh7fff :
		(y_full < -19'sd32768) ? 16'sh8000 : y_full[15:0];

	assign div_start = ((state_q == S_BSTART) && (s2_q != '0)) || (state_q == S_MAG);
	assign div_num = (state_q == S_MAG) ? DIVN_W'({mag, STEP_SHIFT'(0)}) :
		DIVN_W'({abs_v, 31'd0}) + DIVN_W'(abs_s2 >> 1);
	assign div_den = (state_q == S_MAG) ? norm_q : NORM_W'(abs_s2);

	assign raw_we = acc_pat;
	assign raw_raddr = TAW'(bp_q - 1'b1 - j_q);
	assign tap_we = ((state_q == S_BSTART) && (s2_q == '0)) || ((state_q == S_BWAIT) && div_rsp.done);
	assign tap_wd = (state_q == S_BSTART) ? zero_tap : div_tap;
	assign norm_we = (state_q == S_NK) && (k_q == tap_cnt_q);
	assign meas_we = (acc_sig && (int'(smp_cnt_q) < MAX_SIGNAL)) ||
		((state_q == S_INIT) && (i_q >= SKW'(len_q)));
	assign meas_waddr = (state_q == S_INIT) ? SAW'(i_q) : SAW'(smp_cnt_q);
	assign meas_wd = (state_q == S_INIT) ? 16'sd0 : value;
	assign est_we = (state_q == S_INIT) || ((state_q == S_UWR) && tnz_s1) ||
		((state_q == S_CWR) && est_rd[31]);
	assign est_waddr = (state_q == S_UWR) ? c_addr : SAW'(i_q);
	assign est_wd = (state_q == S_UWR) ? est_upd : 32'sd0;
	assign est_raddr = ((state_q == S_CRD) || (state_q == S_ORD)) ? SAW'(i_q) : c_addr;

	ksr_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_raw (
		.clk(clk), .we(raw_we), .waddr(TAW'(pat_idx)), .wdata(value),
		.raddr(raw_raddr), .rdata(raw_rd)
	);

	ksr_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_tap (
		.clk(clk), .we(tap_we), .waddr(TAW'(j_q)), .wdata(tap_wd),
		.raddr(TAW'(k_q)), .rdata(tap_rd)
	);

	ksr_ram #(.WIDTH(NORM_W), .DEPTH(SIG_CAP)) u_norm (
		.clk(clk), .we(norm_we), .waddr(SAW'(i_q)), .wdata(acc_q),
		.raddr(SAW'(i_q)), .rdata(norm_rd)
	);

	ksr_ram #(.WIDTH(16), .DEPTH(SIG_CAP)) u_meas (
		.clk(clk), .we(meas_we), .waddr(meas_waddr), .wdata(meas_wd),
		.raddr(SAW'(i_q)), .rdata(meas_rd)
	);

	ksr_ram #(.WIDTH(32), .DEPTH(SIG_CAP)) u_est (
		.clk(clk), .we(est_we), .waddr(est_waddr), .wdata(est_wd),
		.raddr(est_raddr), .rdata(est_rd)
	);

	ksr_div #(.NUM_W(DIVN_W), .DEN_W(NORM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_num), .divisor(div_den), .rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pat_cnt_q <= '0;
			smp_cnt_q <= '0;
			prev_val_q <= '0;
			prev_pos_q <= '0;
			term_q <= '0;
			term_en_q <= 1'b0;
			s2_q <= '0;
			zero_seen_q <= 1'b0;
			zero_idx_q <= '0;
			centre_q <= '0;
			tap_cnt_q <= '0;
			bp_q <= '0;
			j_q <= '0;
			neg_q <= 1'b0;
			i_q <= '0;
			m_q <= '0;
			n_q <= '0;
			len_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			dot_q <= '0;
			norm_q <= '0;
			meas_q <= '0;
			r_q <= '0;
			step_q <= '0;
			sw_q <= '0;
			prod_s1 <= '0;
			est_s1 <= '0;
			tnz_s1 <= 1'b0;
			strobe_q <= 1'b0;
			sample_q <= '0;
			index_q <= '0;
			last_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_pat) begin
						pat_cnt_q <= pat_idx + 1'b1;
						term_q <= term_p;
						term_en_q <= (pat_idx != '0);
						prev_val_q <= value;
						prev_pos_q <= position;
						tap_cnt_q <= '0;
						bp_q <= p_used;
						if (position == 16'sd0) begin
							zero_seen_q <= 1'b1;
							zero_idx_q <= TAW'(pat_idx);
						end else if (pat_idx == '0) begin
							zero_seen_q <= 1'b0;
						end
						state_q <= S_PACC;
					end else if (acc_sig) begin
						if (smp_next >= (LW + 1)'(len_used)) begin
							smp_cnt_q <= '0;
							len_q <= len_used;
							i_q <= '0;
							m_q <= '0;
							state_q <= S_INIT;
						end else begin
							smp_cnt_q <= LW'(smp_next);
						end
					end
				end
				S_PACC: begin
					s2_q <= term_en_q ? s2_q + S2_W'(term_q) : '0;
					j_q <= '0;
					state_q <= (pat_cnt_q == bp_q) ? S_BRD : S_IDLE;
				end
				S_BRD: begin
					state_q <= S_BSTART;
				end
				S_BSTART: begin
					neg_q <= raw_rd[15] ^ s2_q[S2_W-1];
					if (s2_q == '0) begin
						j_q <= j_q + 1'b1;
						if ((j_q + 1'b1) == bp_q) begin
							tap_cnt_q <= bp_q;
							centre_q <= zero_seen_q ? TAW'(bp_q - 1'b1 - TKW'(zero_idx_q)) : '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_BRD;
						end
					end else begin
						state_q <= S_BWAIT;
					end
				end
				S_BWAIT: begin
					if (div_rsp.done) begin
						j_q <= j_q + 1'b1;
						if ((j_q + 1'b1) == bp_q) begin
							tap_cnt_q <= bp_q;
							centre_q <= zero_seen_q ? TAW'(bp_q - 1'b1 - TKW'(zero_idx_q)) : '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_BRD;
						end
					end
				end
				S_INIT: begin
					if (((i_q + 1'b1) >= SKW'(len_q)) && (m_q == MW'(PAD_MULTIPLE - 1))) begin
						n_q <= i_q + 1'b1;
						i_q <= '0;
						k_q <= '0;
						acc_q <= '0;
						state_q <= S_NK;
					end else begin
						i_q <= i_q + 1'b1;
						m_q <= (m_q == MW'(PAD_MULTIPLE - 1)) ? '0 : m_q + 1'b1;
					end
				end
				S_NK: begin
					if (k_q == tap_cnt_q) begin
						k_q <= '0;
						acc_q <= '0;
						if (row_last) begin
							i_q <= '0;
							sw_q <= '0;
							state_q <= (cfg.sweep_count == 10'd0) ? S_ORD : S_RROW;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else if (!c_ok) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_NMUL;
					end
				end
				S_NMUL: begin
					prod_s1 <= mul_p;
					state_q <= S_NACC;
				end
				S_NACC: begin
					acc_q <= acc_q + NORM_W'(prod_s1[63:NORM_SHIFT]);
					k_q <= k_q + 1'b1;
					state_q <= S_NK;
				end
				S_RROW: begin
					state_q <= S_RNORM;
				end
				S_RNORM: begin
					if (norm_rd == '0) begin
						if (row_last) begin
							i_q <= '0;
							state_q <= S_CRD;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_RROW;
						end
					end else begin
						norm_q <= norm_rd;
						meas_q <= meas_rd;
						dot_q <= '0;
						k_q <= '0;
						state_q <= S_DK;
					end
				end
				S_DK: begin
					if (k_q == tap_cnt_q) begin
						state_q <= S_RES;
					end else if (!c_ok) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					prod_s1 <= mul_p;
					state_q <= S_DACC;
				end
				S_DACC: begin
					dot_q <= dot_q + DOT_W'(prod_s1 >>> PROD_SHIFT);
					k_q <= k_q + 1'b1;
					state_q <= S_DK;
				end
				S_RES: begin
					r_q <= sat32((64'(meas_q) <<< EST_FRAC) - 64'(dot_q));
					state_q <= S_MAG;
				end
				S_MAG: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_rsp.done) begin
						step_q <= r_q[31] ? -$signed(q_sat) : $signed(q_sat);
						k_q <= '0;
						state_q <= S_UK;
					end
				end
				S_UK: begin
					if (k_q == tap_cnt_q) begin
						if (row_last) begin
							i_q <= '0;
							state_q <= S_CRD;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_RROW;
						end
					end else if (!c_ok) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_UMUL;
					end
				end
				S_UMUL: begin
					prod_s1 <= mul_p;
					est_s1 <= est_rd;
					tnz_s1 <= (tap_rd != 32'sd0);
					state_q <= S_UWR;
				end
				S_UWR: begin
					k_q <= k_q + 1'b1;
					state_q <= S_UK;
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (row_last) begin
						i_q <= '0;
						if ((11'(sw_q) + 1'b1) == 11'(cfg.sweep_count)) begin
							state_q <= S_ORD;
						end else begin
							sw_q <= sw_q + 1'b1;
							state_q <= S_RROW;
						end
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_ORD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					strobe_q <= 1'b1;
					sample_q <= y_sat;
					index_q <= 6'(i_q);
					last_q <= ((i_q + 1'b1) == SKW'(len_q));
					if ((i_q + 1'b1) == SKW'(len_q)) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_ORD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign restored_sample = sample_q;
	assign sample_index = index_q;
	assign last = last_q;

	a_strobe_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == S_OUT))
		else $error("result strobe without a readout cycle");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_BWAIT || state_q == S_DWAIT))
		else $error("divider finished while nobody waits for it");

	a_update_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UWR) |-> c_ok)
		else $error("estimate update outside the padded signal");

	a_readout_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (i_q < SKW'(len_q)))
		else $error("readout index beyond the signal length");

endmodule

[hdl/kaczmarz_signal_restorer.sv]
// Top level of the Kaczmarz signal restorer: APB register file and core.
// Depends on ksr_pkg and ksr_core.
//
// Usage: configure signal_length, pattern_length, relax_gain and sweep_count
// over the APB port (byte addresses 0, 4, 8, 12) while the block is idle.
// An input transaction is taken when start is high and busy is low; action 0
// loads one blur pattern point, action 1 loads one signal sample.
// A pattern point that does not complete the pattern keeps busy high for one
// cycle. The completing point builds the taps one at a time, each through
// a divider pass unless the pattern area is zero. A signal sample that does
// not complete the signal leaves busy low. The completing sample starts a
// run: the signal is zero-padded to a multiple of PAD_MULTIPLE, row norms
// are built, sweep_count Kaczmarz sweeps run, each ending by clamping
// negative estimates to zero, and the estimate is read out.
// Results leave one at a time at the end of the run, each marked by
// strobe for exactly one cycle; the receiver cannot stall them.
// Reset returns the registers to their defaults and clears all load counters;
// the taps are unusable until a full pattern has been loaded.
module kaczmarz_signal_restorer import ksr_pkg::*; #(
	parameter int MAX_SIGNAL = 64,
	parameter int MAX_TAPS = 32,
	parameter int PAD_MULTIPLE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic signed [15:0] value,
	input  logic signed [15:0] position,
	output logic               strobe,
	output logic signed [15:0] restored_sample,
	output logic [5:0]         sample_index,
	output logic               last
);

	localparam logic [1:0] REG_SIGNAL_LENGTH = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_RELAX_GAIN = 2'd2;
	localparam logic [1:0] REG_SWEEP_COUNT = 2'd3;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signal_length <= SIGNAL_LENGTH_RST;
			cfg_q.pattern_length <= PATTERN_LENGTH_RST;
			cfg_q.relax_gain <= RELAX_GAIN_RST;
			cfg_q.sweep_count <= SWEEP_COUNT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SIGNAL_LENGTH: begin
					cfg_q.signal_length <= pwdata[6:0];
				end
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= pwdata[5:0];
				end
				REG_RELAX_GAIN: begin
					cfg_q.relax_gain <= pwdata[15:0];
				end
				REG_SWEEP_COUNT: begin
					cfg_q.sweep_count <= pwdata[9:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SIGNAL_LENGTH: begin
				prdata = 32'(cfg_q.signal_length);
			end
			REG_PATTERN_LENGTH: begin
				prdata = 32'(cfg_q.pattern_length);
			end
			REG_RELAX_GAIN: begin
				prdata = 32'(cfg_q.relax_gain);
			end
			REG_SWEEP_COUNT: begin
				prdata = 32'(cfg_q.sweep_count);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	ksr_core #(
		.MAX_SIGNAL(MAX_SIGNAL),
		.MAX_TAPS(MAX_TAPS),
		.PAD_MULTIPLE(PAD_MULTIPLE)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(start),
		.action(action),
		.value(value),
		.position(position),
		.busy(busy),
		.strobe(strobe),
		.restored_sample(restored_sample),
		.sample_index(sample_index),
		.last(last)
	);

endmodule
